// ===== design/clexp_pkg.sv =====
// shared types, constants and microcode for the char lcd expander sequencer
`timescale 1ns / 1ps
`default_nettype none

package clexp_pkg;

   // request kinds
   typedef enum logic [2:0] {
      FUNC_INIT   = 3'd0,
      FUNC_CLEAR  = 3'd1,
      FUNC_CURSOR = 3'd2,
      FUNC_CHAR   = 3'd3,
      FUNC_NUMBER = 3'd4,
      FUNC_RAW    = 3'd5
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] value;
      logic [7:0]  row;
      logic [7:0]  col;
   } req_word_type;

   typedef struct packed {
      logic [6:0] target_address;
      logic [7:0] expander_byte;
      logic [4:0] wait_before_ms;
      logic [2:0] wait_after_ms;
      logic       last;
   } rsp_word_type;

   localparam logic [6:0] ADDR_RESET     = 7'h27;
   localparam logic [4:0] WAIT_POWER_ON  = 5'd20;
   localparam logic [2:0] WAIT_DEFAULT   = 3'd1;
   localparam logic [2:0] WAIT_CLEAR     = 3'd4;
   localparam logic [7:0] LINE1_BASE     = 8'h80;
   localparam logic [7:0] LINE2_BASE     = 8'hC0;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] ROW_SECOND     = 8'd1;
   localparam logic [3:0] ASCII_ZERO_HI  = 4'h3;

   // decimal output
   localparam int NUM_DIGITS = 5;
   localparam int PIDX_W     = $clog2(NUM_DIGITS + 1);
   localparam logic [15:0] PLACES [NUM_DIGITS] = '{
      16'd10000, 16'd1000, 16'd100, 16'd10, 16'd1
   };

   // power-on table
   localparam int INIT_LEN = 28;
   localparam int IDX_W    = $clog2(INIT_LEN);
   localparam logic [7:0] INIT_BYTES [INIT_LEN] = '{
      8'h34, 8'h30, 8'h34, 8'h30, 8'h34, 8'h30,
      8'h24, 8'h20,
      8'h24, 8'h20, 8'h84, 8'h80,
      8'h04, 8'h00, 8'h84, 8'h80,
      8'h04, 8'h00, 8'hC4, 8'hC0,
      8'h04, 8'h00, 8'h2C, 8'h28,
      8'h04, 8'h00, 8'h14, 8'h10
   };
   localparam logic [2:0] INIT_AFTER [INIT_LEN] = '{
      3'd1, 3'd5, 3'd1, 3'd5, 3'd1, 3'd5,
      3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd5,
      3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1
   };

   // microcode
   typedef enum logic [2:0] {
      OP_IDLE,      // wait for a request and dispatch
      OP_INIT,      // stream the power-on table
      OP_EMIT,      // write one nibble phase
      OP_CMD_END,   // last write of a command byte
      OP_DATA_END,  // trailing write of a data byte, then maybe next digit
      OP_DIGIT      // one subtract step of decimal conversion
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       hi;    // send upper nibble of the byte register
      logic       en;
      logic       rs;
      logic [3:0] next;
   } ctl_type;

   localparam logic [3:0] PC_IDLE  = 4'd0;
   localparam logic [3:0] PC_INIT  = 4'd1;
   localparam logic [3:0] PC_C0    = 4'd2;
   localparam logic [3:0] PC_C1    = 4'd3;
   localparam logic [3:0] PC_C2    = 4'd4;
   localparam logic [3:0] PC_C3    = 4'd5;
   localparam logic [3:0] PC_D0    = 4'd6;
   localparam logic [3:0] PC_D1    = 4'd7;
   localparam logic [3:0] PC_D2    = 4'd8;
   localparam logic [3:0] PC_D3    = 4'd9;
   localparam logic [3:0] PC_D4    = 4'd10;
   localparam logic [3:0] PC_DIGIT = 4'd11;

   function automatic ctl_type ctl_word(input logic [3:0] pc);
      ctl_type c;
      case (pc)
         PC_INIT:  c = '{op: OP_INIT,     hi: 1'b0, en: 1'b0, rs: 1'b0, next: PC_IDLE};
         PC_C0:    c = '{op: OP_EMIT,     hi: 1'b1, en: 1'b1, rs: 1'b0, next: PC_C1};
         PC_C1:    c = '{op: OP_EMIT,     hi: 1'b1, en: 1'b0, rs: 1'b0, next: PC_C2};
         PC_C2:    c = '{op: OP_EMIT,     hi: 1'b0, en: 1'b1, rs: 1'b0, next: PC_C3};
         PC_C3:    c = '{op: OP_CMD_END,  hi: 1'b0, en: 1'b0, rs: 1'b0, next: PC_IDLE};
         PC_D0:    c = '{op: OP_EMIT,     hi: 1'b1, en: 1'b1, rs: 1'b1, next: PC_D1};
         PC_D1:    c = '{op: OP_EMIT,     hi: 1'b1, en: 1'b0, rs: 1'b1, next: PC_D2};
         PC_D2:    c = '{op: OP_EMIT,     hi: 1'b0, en: 1'b1, rs: 1'b1, next: PC_D3};
         PC_D3:    c = '{op: OP_EMIT,     hi: 1'b0, en: 1'b0, rs: 1'b1, next: PC_D4};
         PC_D4:    c = '{op: OP_DATA_END, hi: 1'b0, en: 1'b0, rs: 1'b0, next: PC_IDLE};
         PC_DIGIT: c = '{op: OP_DIGIT,    hi: 1'b0, en: 1'b0, rs: 1'b0, next: PC_D0};
         default:  c = '{op: OP_IDLE,     hi: 1'b0, en: 1'b0, rs: 1'b0, next: PC_IDLE};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/char_lcd_expander_sequencer_unit.sv =====
// top level: microcoded sequencer turning lcd requests into expander byte writes
`timescale 1ns / 1ps
`default_nettype none

// Each request word becomes a run of one-byte port expander writes that drive a
// character lcd in 4-bit mode; at most one write leaves per cycle while rsp_stall is low.
// A small microcode rom steps a byte register through its nibble phases. The
// idle state dispatches the request, then init sends 28 writes, clear, cursor and
// raw command 4, a character 5. A number walks the five decimal places by
// repeated subtraction and sends 5 writes per printed digit, leading zeros
// skipped. A new request is taken once the last write of the previous one is in
// the output register. The expander address register is written through csr_,
// which is always ready.
module char_lcd_expander_sequencer_unit
   import clexp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_data
);

   logic [3:0]        pc_ff, pc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;
   logic [6:0]        addr_ff, addr_in;
   logic [7:0]        data_ff, data_in;
   logic              clear_ff, clear_in;
   logic              num_mode_ff, num_mode_in;
   logic [15:0]       num_ff, num_in;
   logic [PIDX_W-1:0] pidx_ff, pidx_in;
   logic [3:0]        digit_ff, digit_in;
   logic              started_ff, started_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   ctl_type    ctl;
   logic       out_free;
   logic       emit;
   logic [7:0] emit_byte;
   logic [4:0] emit_before;
   logic [2:0] emit_after;
   logic       emit_last;
   logic [3:0] nib;

   assign req_stall = (pc_ff != PC_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      pc_in       = pc_ff;
      data_in     = data_ff;
      clear_in    = clear_ff;
      num_mode_in = num_mode_ff;
      num_in      = num_ff;
      pidx_in     = pidx_ff;
      digit_in    = digit_ff;
      started_in  = started_ff;
      idx_in      = idx_ff;
      addr_in     = (csr_valid && csr_ready) ? csr_data : addr_ff;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_before = '0;
      emit_after  = WAIT_DEFAULT;
      emit_last   = 1'b0;
      ctl         = ctl_word(pc_ff);
      out_free    = !rsp_valid_ff || !rsp_stall;
      nib         = ctl.hi ? data_ff[7:4] : data_ff[3:0];

      case (ctl.op)
         OP_IDLE: begin
            if (req_valid) begin
               clear_in    = 1'b0;
               num_mode_in = 1'b0;
               case (req_data.func)
                  FUNC_INIT: begin
                     idx_in = '0;
                     pc_in  = PC_INIT;
                  end
                  FUNC_CLEAR: begin
                     data_in  = CMD_CLEAR;
                     clear_in = 1'b1;
                     pc_in    = PC_C0;
                  end
                  FUNC_CURSOR: begin
                     data_in = ((req_data.row == ROW_SECOND) ? LINE2_BASE : LINE1_BASE)
                               + req_data.col;
                     pc_in   = PC_C0;
                  end
                  FUNC_CHAR: begin
                     data_in = req_data.value[7:0];
                     pc_in   = PC_D0;
                  end
                  FUNC_NUMBER: begin
                     num_in      = req_data.value;
                     num_mode_in = 1'b1;
                     pidx_in     = '0;
                     digit_in    = '0;
                     started_in  = 1'b0;
                     pc_in       = PC_DIGIT;
                  end
                  FUNC_RAW: begin
                     data_in = req_data.value[7:0];
                     pc_in   = PC_C0;
                  end
                  default: begin
                     // unused kinds are dropped with no writes
                     pc_in = PC_IDLE;
                  end
               endcase
            end
         end
         OP_INIT: begin
            emit        = 1'b1;
            emit_byte   = INIT_BYTES[idx_ff];
            emit_before = (idx_ff == '0) ? WAIT_POWER_ON : 5'd0;
            emit_after  = INIT_AFTER[idx_ff];
            emit_last   = (idx_ff == IDX_W'(INIT_LEN - 1));
            if (out_free) begin
               if (emit_last) begin
                  pc_in = ctl.next;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         OP_EMIT, OP_CMD_END, OP_DATA_END: begin
            emit      = 1'b1;
            emit_byte = {nib, 1'b1, ctl.en, 1'b0, ctl.rs};
            if (ctl.op == OP_CMD_END) begin
               emit_last  = 1'b1;
               emit_after = clear_ff ? WAIT_CLEAR : WAIT_DEFAULT;
            end else if (ctl.op == OP_DATA_END) begin
               emit_last = !num_mode_ff || (pidx_ff == PIDX_W'(NUM_DIGITS));
            end
            if (out_free) begin
               pc_in = (ctl.op == OP_DATA_END && !emit_last) ? PC_DIGIT : ctl.next;
            end
         end
         OP_DIGIT: begin
            if (num_ff >= PLACES[pidx_ff]) begin
               num_in   = num_ff - PLACES[pidx_ff];
               digit_in = digit_ff + 1'b1;
            end else begin
               pidx_in  = pidx_ff + 1'b1;
               digit_in = '0;
               // leading zeros are skipped, but the ones place always prints
               if (digit_ff != '0 || started_ff || pidx_ff == PIDX_W'(NUM_DIGITS - 1)) begin
                  data_in    = {ASCII_ZERO_HI, digit_ff};
                  started_in = 1'b1;
                  pc_in      = ctl.next;
               end
            end
         end
         default: begin
            pc_in = PC_IDLE;
         end
      endcase

      rsp_in = rsp_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{target_address: addr_ff, expander_byte: emit_byte,
                          wait_before_ms: emit_before, wait_after_ms: emit_after,
                          last: emit_last};
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= ADDR_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
      end
      rsp_ff      <= rsp_in;
      data_ff     <= data_in;
      clear_ff    <= clear_in;
      num_mode_ff <= num_mode_in;
      num_ff      <= num_in;
      pidx_ff     <= pidx_in;
      digit_ff    <= digit_in;
      started_ff  <= started_in;
      idx_ff      <= idx_in;
   end

`ifndef SYNTHESIS
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_DIGIT) |-> (digit_ff <= 4'd9 && pidx_ff < PIDX_W'(NUM_DIGITS)))
      else $error("decimal conversion out of range");

   a_init_index: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_INIT) |-> (idx_ff <= IDX_W'(INIT_LEN - 1)))
      else $error("init table index out of range");

   a_take_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && pc_ff == PC_IDLE && $past(pc_ff) != PC_IDLE)
      |-> $past(rsp_valid_in && rsp_in.last))
      else $error("request taken before previous run finished");
`endif

endmodule

`default_nettype wire
